>>> design/minkowski_support_point_defines.svh
// ----------------------------------------------------------------------------
// minkowski_support_point_defines.svh
// Assertion macros shared by the checker of the support point block.
// ----------------------------------------------------------------------------
`ifndef MINKOWSKI_SUPPORT_POINT_DEFINES_SVH
`define MINKOWSKI_SUPPORT_POINT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared constants, types and helpers of the Minkowski support point block.
// ----------------------------------------------------------------------------
package msp_pkg;

	localparam int MAX_POINTS   = 16;
	localparam int COORD_BITS   = 16;
	localparam int FIELD_W      = 16;
	localparam int IDX_FIELD_W  = 4;
	localparam int DIFF_FIELD_W = 17;
	localparam int COORD_W      = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
	localparam int IDX_W        = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int NUM_W        = IDX_W + 1;
	localparam int CNT_W        = 5;
	localparam int PROD_W       = 2 * COORD_W;
	localparam int DOT_W        = PROD_W + 2;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;

	localparam logic REG_COUNT_A = 1'b0;
	localparam logic REG_COUNT_B = 1'b1;
	localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(8);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;
	localparam logic SET_A      = 1'b0;
	localparam logic SET_B      = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} point_t;

	// read issue tag that travels alongside a memory read
	typedef struct packed {
		logic             vld;
		logic             first;
		logic             last;
		logic [IDX_W-1:0] idx;
	} scan_tag_t;

	// lane status back to the sequencer
	typedef struct packed {
		logic             done;
		logic [IDX_W-1:0] idx;
		point_t           pt;
	} lane_res_t;

	// count register to number of points scanned: zero acts as one, clamp at the top
	function automatic logic [NUM_W-1:0] active_count(input logic [CNT_W-1:0] c);
		logic [NUM_W-1:0] n;
		if (c == '0) begin
			n = NUM_W'(1);
		end else if (int'(c) > MAX_POINTS) begin
			n = NUM_W'(MAX_POINTS);
		end else begin
			n = NUM_W'(c);
		end
		return n;
	endfunction

endpackage

>>> design/msp_point_mem.sv
// ----------------------------------------------------------------------------
// msp_point_mem
// One point set: synchronous memory, one write port, one registered read port.
// ----------------------------------------------------------------------------
module msp_point_mem (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [msp_pkg::IDX_W-1:0] wr_addr,
	input  msp_pkg::point_t          wr_data,
	input  logic                     rd_en,
	input  logic [msp_pkg::IDX_W-1:0] rd_addr,
	output msp_pkg::point_t          rd_data
);

	msp_pkg::point_t mem_q [msp_pkg::MAX_POINTS];
	msp_pkg::point_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/msp_scan_lane.sv
// ----------------------------------------------------------------------------
// msp_scan_lane
// Dot product and running extremum over the points read from one set.
// ----------------------------------------------------------------------------
module msp_scan_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                find_min,
	input  msp_pkg::point_t     dir,
	input  msp_pkg::scan_tag_t  tag,
	input  msp_pkg::point_t     rd_data,
	output msp_pkg::lane_res_t  res
);

	msp_pkg::scan_tag_t tag_s1, tag_s2, tag_s3;
	msp_pkg::point_t    pt_s2, pt_s3;
	logic signed [msp_pkg::PROD_W-1:0] prod_x_s2, prod_y_s2, prod_z_s2;
	logic signed [msp_pkg::DOT_W-1:0]  dot_s3;
	logic signed [msp_pkg::DOT_W-1:0]  best_dot_q;
	logic [msp_pkg::IDX_W-1:0]         best_idx_q;
	msp_pkg::point_t                   best_pt_q;
	logic                              done_q;
	logic                              better;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			done_q <= 1'b0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			// drop the old result as soon as a new scan starts
			if (tag.vld && tag.first) begin
				done_q <= 1'b0;
			end else if (tag_s3.vld && tag_s3.last) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		pt_s2     <= rd_data;
		prod_x_s2 <= rd_data.x * dir.x;
		prod_y_s2 <= rd_data.y * dir.y;
		prod_z_s2 <= rd_data.z * dir.z;
		pt_s3     <= pt_s2;
		dot_s3    <= msp_pkg::DOT_W'(prod_x_s2) + msp_pkg::DOT_W'(prod_y_s2)
			+ msp_pkg::DOT_W'(prod_z_s2);
	end

	// strict compare keeps the lower index on a tie
	always_comb begin
		if (find_min) begin
			better = dot_s3 < best_dot_q;
		end else begin
			better = dot_s3 > best_dot_q;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s3.vld && (tag_s3.first || better)) begin
			best_dot_q <= dot_s3;
			best_idx_q <= tag_s3.idx;
			best_pt_q  <= pt_s3;
		end
	end

	assign res.done = done_q;
	assign res.idx  = best_idx_q;
	assign res.pt   = best_pt_q;

endmodule

>>> design/minkowski_support_point.sv
// ----------------------------------------------------------------------------
// minkowski_support_point
// Support point of the Minkowski difference A - B of two stored point sets.
// A write item leaves the block idle; it takes the next item in the cycle after.
// A query holds off further items until its result appears, and the next item
// is taken in that same cycle. One read port per set memory reads one point a
// cycle, up to M, the larger of the two active counts (1..16).
// Reset clears control and sets both counts to 8; point memories are not cleared.
// ----------------------------------------------------------------------------
module minkowski_support_point (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   req_valid,
	output logic                                   req_stall,
	input  logic                                   func,
	input  logic                                   set_select,
	input  logic [3:0]                             point_index,
	input  logic signed [msp_pkg::FIELD_W-1:0]     point_x,
	input  logic signed [msp_pkg::FIELD_W-1:0]     point_y,
	input  logic signed [msp_pkg::FIELD_W-1:0]     point_z,
	input  logic signed [msp_pkg::FIELD_W-1:0]     dir_x,
	input  logic signed [msp_pkg::FIELD_W-1:0]     dir_y,
	input  logic signed [msp_pkg::FIELD_W-1:0]     dir_z,
	output logic                                   rsp_valid,
	input  logic                                   rsp_stall,
	output logic [msp_pkg::IDX_FIELD_W-1:0]        index_a,
	output logic [msp_pkg::IDX_FIELD_W-1:0]        index_b,
	output logic signed [msp_pkg::FIELD_W-1:0]     a_x,
	output logic signed [msp_pkg::FIELD_W-1:0]     a_y,
	output logic signed [msp_pkg::FIELD_W-1:0]     a_z,
	output logic signed [msp_pkg::FIELD_W-1:0]     b_x,
	output logic signed [msp_pkg::FIELD_W-1:0]     b_y,
	output logic signed [msp_pkg::FIELD_W-1:0]     b_z,
	output logic signed [msp_pkg::DIFF_FIELD_W-1:0] diff_x,
	output logic signed [msp_pkg::DIFF_FIELD_W-1:0] diff_y,
	output logic signed [msp_pkg::DIFF_FIELD_W-1:0] diff_z,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [msp_pkg::PADDR_W-1:0]            paddr,
	input  logic [msp_pkg::PDATA_W-1:0]            pwdata,
	output logic [msp_pkg::PDATA_W-1:0]            prdata,
	output logic                                   pready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [msp_pkg::CNT_W-1:0] count_a_q, count_b_q;
	logic                      cfg_wr;
	logic                      reg_sel;

	logic [1:0]                state_q;
	logic [msp_pkg::IDX_W-1:0] ptr_q;
	logic [msp_pkg::NUM_W-1:0] num_a_q, num_b_q;
	logic [msp_pkg::IDX_W-1:0] ptr_last_q;
	msp_pkg::point_t           dir_q;

	logic                      req_accept;
	logic                      query_start;
	logic                      point_wr;
	logic                      slot_ok;
	logic [msp_pkg::IDX_W-1:0] wr_slot;
	logic [msp_pkg::NUM_W-1:0] num_a, num_b, num_max;
	logic [msp_pkg::NUM_W-1:0] ptr_ext;
	logic                      scanning;
	logic                      finish;

	msp_pkg::point_t           wr_point;
	msp_pkg::point_t           rd_a, rd_b;
	msp_pkg::scan_tag_t        tag_a, tag_b;
	msp_pkg::lane_res_t        res_a, res_b;

	logic                      rsp_valid_q;
	logic [msp_pkg::IDX_W-1:0] idx_a_q, idx_b_q;
	msp_pkg::point_t           pt_a_q, pt_b_q;
	logic signed [msp_pkg::DIFF_W-1:0] diff_x_q, diff_y_q, diff_z_q;

	// configuration port
	assign pready  = 1'b1;
	assign reg_sel = paddr[msp_pkg::PADDR_W-1];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q <= msp_pkg::COUNT_RESET;
			count_b_q <= msp_pkg::COUNT_RESET;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				msp_pkg::REG_COUNT_A: count_a_q <= pwdata[msp_pkg::CNT_W-1:0];
				msp_pkg::REG_COUNT_B: count_b_q <= pwdata[msp_pkg::CNT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			msp_pkg::REG_COUNT_A: prdata = msp_pkg::PDATA_W'(count_a_q);
			msp_pkg::REG_COUNT_B: prdata = msp_pkg::PDATA_W'(count_b_q);
		endcase
	end

	// request side
	assign req_stall   = (state_q != ST_IDLE);
	assign req_accept  = req_valid && !req_stall;
	assign query_start = req_accept && (func == msp_pkg::FUNC_QUERY);
	assign point_wr    = req_accept && (func == msp_pkg::FUNC_WRITE);

	// drop writes to slots beyond the set size
	assign slot_ok = (int'(point_index) < msp_pkg::MAX_POINTS);
	assign wr_slot = msp_pkg::IDX_W'(point_index);

	assign wr_point.x = point_x[msp_pkg::COORD_W-1:0];
	assign wr_point.y = point_y[msp_pkg::COORD_W-1:0];
	assign wr_point.z = point_z[msp_pkg::COORD_W-1:0];

	assign num_a   = msp_pkg::active_count(count_a_q);
	assign num_b   = msp_pkg::active_count(count_b_q);
	assign num_max = (num_a > num_b) ? num_a : num_b;

	// scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (query_start) begin
						state_q <= ST_SCAN;
						ptr_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (ptr_q == ptr_last_q) begin
						state_q <= ST_WAIT;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_WAIT: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (query_start) begin
			num_a_q    <= num_a;
			num_b_q    <= num_b;
			ptr_last_q <= msp_pkg::IDX_W'(num_max - 1'b1);
			dir_q.x    <= dir_x[msp_pkg::COORD_W-1:0];
			dir_q.y    <= dir_y[msp_pkg::COORD_W-1:0];
			dir_q.z    <= dir_z[msp_pkg::COORD_W-1:0];
		end
	end

	assign scanning = (state_q == ST_SCAN);
	assign ptr_ext  = {1'b0, ptr_q};

	assign tag_a.vld   = scanning && (ptr_ext < num_a_q);
	assign tag_a.first = (ptr_q == '0);
	assign tag_a.last  = (ptr_ext == num_a_q - 1'b1);
	assign tag_a.idx   = ptr_q;
	assign tag_b.vld   = scanning && (ptr_ext < num_b_q);
	assign tag_b.first = (ptr_q == '0);
	assign tag_b.last  = (ptr_ext == num_b_q - 1'b1);
	assign tag_b.idx   = ptr_q;

	msp_point_mem u_mem_a (
		.clk     (clk),
		.wr_en   (point_wr && slot_ok && (set_select == msp_pkg::SET_A)),
		.wr_addr (wr_slot),
		.wr_data (wr_point),
		.rd_en   (scanning),
		.rd_addr (ptr_q),
		.rd_data (rd_a)
	);

	msp_point_mem u_mem_b (
		.clk     (clk),
		.wr_en   (point_wr && slot_ok && (set_select == msp_pkg::SET_B)),
		.wr_addr (wr_slot),
		.wr_data (wr_point),
		.rd_en   (scanning),
		.rd_addr (ptr_q),
		.rd_data (rd_b)
	);

	// B is searched along the negated direction: smallest dot with d
	msp_scan_lane u_lane_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.find_min (1'b0),
		.dir      (dir_q),
		.tag      (tag_a),
		.rd_data  (rd_a),
		.res      (res_a)
	);

	msp_scan_lane u_lane_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.find_min (1'b1),
		.dir      (dir_q),
		.tag      (tag_b),
		.rd_data  (rd_b),
		.res      (res_b)
	);

	// result register: load once both lanes are done and the slot is free
	assign finish = (state_q == ST_WAIT) && res_a.done && res_b.done
		&& (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			idx_a_q  <= res_a.idx;
			idx_b_q  <= res_b.idx;
			pt_a_q   <= res_a.pt;
			pt_b_q   <= res_b.pt;
			diff_x_q <= msp_pkg::DIFF_W'(res_a.pt.x) - msp_pkg::DIFF_W'(res_b.pt.x);
			diff_y_q <= msp_pkg::DIFF_W'(res_a.pt.y) - msp_pkg::DIFF_W'(res_b.pt.y);
			diff_z_q <= msp_pkg::DIFF_W'(res_a.pt.z) - msp_pkg::DIFF_W'(res_b.pt.z);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign index_a   = msp_pkg::IDX_FIELD_W'(idx_a_q);
	assign index_b   = msp_pkg::IDX_FIELD_W'(idx_b_q);
	assign a_x       = msp_pkg::FIELD_W'(pt_a_q.x);
	assign a_y       = msp_pkg::FIELD_W'(pt_a_q.y);
	assign a_z       = msp_pkg::FIELD_W'(pt_a_q.z);
	assign b_x       = msp_pkg::FIELD_W'(pt_b_q.x);
	assign b_y       = msp_pkg::FIELD_W'(pt_b_q.y);
	assign b_z       = msp_pkg::FIELD_W'(pt_b_q.z);
	assign diff_x    = msp_pkg::DIFF_FIELD_W'(diff_x_q);
	assign diff_y    = msp_pkg::DIFF_FIELD_W'(diff_y_q);
	assign diff_z    = msp_pkg::DIFF_FIELD_W'(diff_z_q);

endmodule

>>> design/msp_checker.sv
// ----------------------------------------------------------------------------
// msp_checker
// Port-level checks of the support point block, bound to the top level.
// ----------------------------------------------------------------------------
`include "minkowski_support_point_defines.svh"

module msp_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    req_valid,
	input logic                                    req_stall,
	input logic                                    func,
	input logic                                    rsp_valid,
	input logic                                    rsp_stall,
	input logic [msp_pkg::IDX_FIELD_W-1:0]         index_a,
	input logic [msp_pkg::IDX_FIELD_W-1:0]         index_b,
	input logic signed [msp_pkg::DIFF_FIELD_W-1:0] diff_x,
	input logic signed [msp_pkg::DIFF_FIELD_W-1:0] diff_y,
	input logic signed [msp_pkg::DIFF_FIELD_W-1:0] diff_z
);

	// hold a stalled result beat
	`MSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(index_a) && $stable(index_b) && $stable(diff_x) && $stable(diff_y) && $stable(diff_z), "stalled result beat changed")

	// a query occupies the block right after it is taken
	`MSP_ASSERT_NEXT(a_query_busy, req_valid && !req_stall && (func == msp_pkg::FUNC_QUERY), req_stall, "query did not start a scan")

	// a point write never blocks the next beat
	`MSP_ASSERT_NEXT(a_write_free, req_valid && !req_stall && (func == msp_pkg::FUNC_WRITE), !req_stall, "point write stalled the request side")

	// a result only appears at the end of a scan
	`MSP_ASSERT_NOW(a_rsp_from_scan, $rose(rsp_valid), $past(req_stall), "result without a scan")

endmodule

bind minkowski_support_point msp_checker u_msp_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Minkowski support point block. Point writes and
// support queries are streamed over the request channel while a shadow model of
// both point sets predicts every query result. Results are compared in order,
// field by field. Set counts change over APB between phases. Before the last two
// phases both channels are throttled at random, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 25;
	localparam int PHASE_ITEMS    = 210;
	localparam int NUM_PHASES     = 6;
	localparam int MAX_PRINTS     = 200;

	typedef struct {
		logic            func;
		logic            set_sel;
		logic [3:0]      slot;
		msp_pkg::coord_t px, py, pz;
		msp_pkg::coord_t dx, dy, dz;
	} sp_item_t;

	typedef struct {
		msp_pkg::coord_t x, y, z;
	} xyz_t;

	typedef struct {
		logic [3:0]         ia, ib;
		msp_pkg::coord_t    ax, ay, az;
		msp_pkg::coord_t    bx, by, bz;
		logic signed [16:0] ddx, ddy, ddz;
	} sp_support_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               req_valid = 1'b0;
	logic               req_stall;
	logic               func = msp_pkg::FUNC_WRITE;
	logic               set_select = msp_pkg::SET_A;
	logic [3:0]         point_index = '0;
	logic signed [15:0] point_x = '0, point_y = '0, point_z = '0;
	logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [3:0]         index_a, index_b;
	logic signed [15:0] a_x, a_y, a_z, b_x, b_y, b_z;
	logic signed [16:0] diff_x, diff_y, diff_z;
	logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [msp_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	sp_item_t    pending_items[$];
	sp_support_t expected_support[$];
	sp_item_t    cur_item;
	xyz_t        pts_a[msp_pkg::MAX_POINTS];
	xyz_t        pts_b[msp_pkg::MAX_POINTS];
	logic [4:0]  num_a = 5'd8;
	logic [4:0]  num_b = 5'd8;

	int   tx_idle_pct = 29;
	int   rx_idle_pct = 61;
	logic hold_go = 1'b0;
	logic hold_off = 1'b0;
	int   err_count = 0;
	int   quiet_cycles = 0;

	minkowski_support_point u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.func(func), .set_select(set_select), .point_index(point_index),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.index_a(index_a), .index_b(index_b),
		.a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.diff_x(diff_x), .diff_y(diff_y), .diff_z(diff_z),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (err_count < MAX_PRINTS)
			$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	task automatic check_field(input string what, input longint got, input longint want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	task automatic queue_pending(input sp_item_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	function automatic int points_scanned(input logic [4:0] c);
		if (c == 5'd0)
			return 1;
		if (int'(c) > msp_pkg::MAX_POINTS)
			return msp_pkg::MAX_POINTS;
		return int'(c);
	endfunction

	function automatic longint dot_dir(input xyz_t p, input longint ex, input longint ey,
			input longint ez);
		return longint'(p.x) * ex + longint'(p.y) * ey + longint'(p.z) * ez;
	endfunction

	function automatic sp_support_t predict_support(input sp_item_t it);
		sp_support_t r;
		longint      best, v;
		int          bi_a, bi_b;
		best = dot_dir(pts_a[0], it.dx, it.dy, it.dz);
		bi_a = 0;
		for (int i = 1; i < points_scanned(num_a); i++) begin
			v = dot_dir(pts_a[i], it.dx, it.dy, it.dz);
			if (v > best) begin
				best = v;
				bi_a = i;
			end
		end
		// B is searched against the direction
		best = dot_dir(pts_b[0], -longint'(it.dx), -longint'(it.dy), -longint'(it.dz));
		bi_b = 0;
		for (int i = 1; i < points_scanned(num_b); i++) begin
			v = dot_dir(pts_b[i], -longint'(it.dx), -longint'(it.dy), -longint'(it.dz));
			if (v > best) begin
				best = v;
				bi_b = i;
			end
		end
		r.ia  = 4'(bi_a);
		r.ib  = 4'(bi_b);
		r.ax  = pts_a[bi_a].x;
		r.ay  = pts_a[bi_a].y;
		r.az  = pts_a[bi_a].z;
		r.bx  = pts_b[bi_b].x;
		r.by  = pts_b[bi_b].y;
		r.bz  = pts_b[bi_b].z;
		r.ddx = 17'(int'(r.ax) - int'(r.bx));
		r.ddy = 17'(int'(r.ay) - int'(r.by));
		r.ddz = 17'(int'(r.az) - int'(r.bz));
		return r;
	endfunction

	task automatic absorb_item(input sp_item_t it);
		xyz_t p;
		if (it.func == msp_pkg::FUNC_QUERY) begin
			expected_support.insert(expected_support.size(), predict_support(it));
		end else if (int'(it.slot) < msp_pkg::MAX_POINTS) begin
			p.x = it.px;
			p.y = it.py;
			p.z = it.pz;
			if (it.set_sel == msp_pkg::SET_B)
				pts_b[it.slot] = p;
			else
				pts_a[it.slot] = p;
		end
	endtask

	// request driver: hold a beat until it is taken, then maybe idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				absorb_item(cur_item);
			if (!req_valid || !req_stall) begin
				if (pending_items.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					cur_item = pending_items.pop_front();
					func        <= cur_item.func;
					set_select  <= cur_item.set_sel;
					point_index <= cur_item.slot;
					point_x     <= cur_item.px;
					point_y     <= cur_item.py;
					point_z     <= cur_item.pz;
					dir_x       <= cur_item.dx;
					dir_y       <= cur_item.dy;
					dir_z       <= cur_item.dz;
					req_valid   <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk)
		rsp_stall <= hold_off || ($urandom_range(0, 99) < rx_idle_pct);

	// result monitor
	always @(posedge clk) begin
		sp_support_t w;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_support.size() == 0) begin
				report_mismatch("unexpected result beat, index_a", index_a, -1);
			end else begin
				w = expected_support.pop_front();
				check_field("index_a", index_a, w.ia);
				check_field("index_b", index_b, w.ib);
				check_field("a_x", a_x, w.ax);
				check_field("a_y", a_y, w.ay);
				check_field("a_z", a_z, w.az);
				check_field("b_x", b_x, w.bx);
				check_field("b_y", b_y, w.by);
				check_field("b_z", b_z, w.bz);
				check_field("diff_x", diff_x, w.ddx);
				check_field("diff_y", diff_y, w.ddy);
				check_field("diff_z", diff_z, w.ddz);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(psel && penable)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL minkowski_support_point");
				$finish;
			end
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	function automatic msp_pkg::coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3: return msp_pkg::coord_t'($urandom_range(0, 2) - 1);
			default: return msp_pkg::coord_t'($urandom);
		endcase
	endfunction

	function automatic sp_item_t write_item(input logic sel, input logic [3:0] slot,
			input msp_pkg::coord_t x, input msp_pkg::coord_t y, input msp_pkg::coord_t z);
		sp_item_t it;
		it.func    = msp_pkg::FUNC_WRITE;
		it.set_sel = sel;
		it.slot    = slot;
		it.px      = x;
		it.py      = y;
		it.pz      = z;
		it.dx      = msp_pkg::coord_t'($urandom);
		it.dy      = msp_pkg::coord_t'($urandom);
		it.dz      = msp_pkg::coord_t'($urandom);
		return it;
	endfunction

	function automatic sp_item_t query_item(input msp_pkg::coord_t x,
			input msp_pkg::coord_t y, input msp_pkg::coord_t z);
		sp_item_t it;
		it.func    = msp_pkg::FUNC_QUERY;
		it.set_sel = 1'($urandom);
		it.slot    = 4'($urandom);
		it.px      = msp_pkg::coord_t'($urandom);
		it.py      = msp_pkg::coord_t'($urandom);
		it.pz      = msp_pkg::coord_t'($urandom);
		it.dx      = x;
		it.dy      = y;
		it.dz      = z;
		return it;
	endfunction

	task automatic apb_write(input logic reg_idx, input logic [4:0] cnt);
		logic [31:0] data;
		data = $urandom_range(0, 1) ? {$urandom} : 32'd0;
		data[4:0] = cnt;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= msp_pkg::PADDR_W'({reg_idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_idx == msp_pkg::REG_COUNT_B)
			num_b = cnt;
		else
			num_a = cnt;
	endtask

	task automatic apb_read_check(input logic reg_idx, input logic [4:0] want);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= msp_pkg::PADDR_W'({reg_idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		check_field("register readback", prdata[4:0], want);
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_items.size() != 0 || req_valid || expected_support.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [4:0] cfg_a[NUM_PHASES];
		logic [4:0] cfg_b[NUM_PHASES];
		cfg_a = '{5'd16, 5'd1, 5'd0, 5'd16, 5'd3, 5'd17};
		cfg_b = '{5'd16, 5'd1, 5'd31, 5'd1, 5'd16, 5'd5};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// extremes in slots 0..4 of both sets, a duplicate in each; random in 5..7
		queue_pending(write_item(msp_pkg::SET_A, 4'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		queue_pending(write_item(msp_pkg::SET_A, 4'd1, 16'sh8000, 16'sh8000, 16'sh8000));
		queue_pending(write_item(msp_pkg::SET_A, 4'd2, 16'sh7FFF, 16'sh8000, 16'sh0000));
		queue_pending(write_item(msp_pkg::SET_A, 4'd3, 16'sh0000, 16'sh0000, 16'sh0000));
		queue_pending(write_item(msp_pkg::SET_A, 4'd4, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		queue_pending(write_item(msp_pkg::SET_B, 4'd0, 16'sh8000, 16'sh8000, 16'sh8000));
		queue_pending(write_item(msp_pkg::SET_B, 4'd1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		queue_pending(write_item(msp_pkg::SET_B, 4'd2, 16'sh0000, 16'sh0000, 16'sh0000));
		queue_pending(write_item(msp_pkg::SET_B, 4'd3, 16'sh8000, 16'sh7FFF, -16'sd1));
		queue_pending(write_item(msp_pkg::SET_B, 4'd4, 16'sh8000, 16'sh8000, 16'sh8000));
		for (int i = 5; i < 8; i++) begin
			queue_pending(write_item(msp_pkg::SET_A, 4'(i), rand_coord(), rand_coord(),
				rand_coord()));
			queue_pending(write_item(msp_pkg::SET_B, 4'(i), rand_coord(), rand_coord(),
				rand_coord()));
		end
		// zero direction ties every point: lowest slots win
		queue_pending(query_item(16'sh0000, 16'sh0000, 16'sh0000));
		queue_pending(query_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		queue_pending(query_item(16'sh8000, 16'sh8000, 16'sh8000));
		queue_pending(query_item(16'sh0001, 16'sh0000, 16'sh0000));
		queue_pending(query_item(16'sh0000, -16'sd1, 16'sh0000));
		queue_pending(query_item(16'sh0000, 16'sh0000, 16'sh7FFF));
		queue_pending(query_item(16'sh8000, 16'sh7FFF, 16'sh8000));
		queue_pending(query_item(rand_coord(), rand_coord(), rand_coord()));
		queue_pending(query_item(rand_coord(), rand_coord(), rand_coord()));
		// fill the upper slots before any count reaches them
		for (int i = 8; i < msp_pkg::MAX_POINTS; i++) begin
			queue_pending(write_item(msp_pkg::SET_A, 4'(i), rand_coord(), rand_coord(),
				rand_coord()));
			queue_pending(write_item(msp_pkg::SET_B, 4'(i), rand_coord(), rand_coord(),
				rand_coord()));
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			apb_write(msp_pkg::REG_COUNT_A, cfg_a[ph]);
			apb_write(msp_pkg::REG_COUNT_B, cfg_b[ph]);
			apb_read_check(msp_pkg::REG_COUNT_A, cfg_a[ph]);
			apb_read_check(msp_pkg::REG_COUNT_B, cfg_b[ph]);
			@(negedge clk);
			case (ph / 2)
				0: begin
					tx_idle_pct = 29;
					rx_idle_pct = 61;
				end
				1: begin
					tx_idle_pct = 61;
					rx_idle_pct = 29;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 99) < 45)
					queue_pending(write_item(1'($urandom), 4'($urandom),
						rand_coord(), rand_coord(), rand_coord()));
				else
					queue_pending(query_item(rand_coord(), rand_coord(),
						rand_coord()));
			end
			if (ph == 0)
				hold_go = 1'b1;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && expected_support.size() == 0) begin
			$display("PASS minkowski_support_point");
		end else begin
			$display("FAIL minkowski_support_point");
		end
		$finish;
	end

endmodule
